[sv/bba_pkg.sv]
// Package: constants, codes, command/status structs and helpers of the buddy block allocator.
`default_nettype none
package bba_pkg;

  localparam int DEEPEST_LEVEL = 4;
  localparam int NODE_COUNT    = (2 << DEEPEST_LEVEL) - 1;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int LVL_W         = 3;
  localparam int LOG2_W        = 6;
  localparam int ADDR_W        = 48;
  localparam int SIZE_W        = 41;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = ADDR_W;
  localparam int LOG2_MIN      = (DEEPEST_LEVEL > 4) ? DEEPEST_LEVEL : 4;
  localparam int LOG2_MAX      = 40;
  localparam int LOG2_RESET    = 20;

  typedef enum logic [1:0] {
    OCC_FULL = 2'd0,
    OCC_FREE = 2'd1,
    OCC_PART = 2'd2
  } occ_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTALLOC = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS    = 1'b0,
    CFG_LOG2_TOTAL_SIZE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              load;
    logic              lvl_latch;
    logic              rd_search;
    logic              take_alloc;
    logic              take_free;
    logic              wr_node;
    logic              result;
    status_t           status;
    logic [NODE_W-1:0] idx;
  } bba_cmd_t;

  typedef struct packed {
    op_t              op;
    logic             too_big;
    logic             in_range;
    logic             occ_free;
    logic             flook_hit;
    logic [LVL_W-1:0] lvl;
    logic             out_free;
  } bba_stat_t;

  function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] v);
    logic [LOG2_W-1:0] r;
    r = v;
    if (v < LOG2_W'(LOG2_MIN)) r = LOG2_W'(LOG2_MIN);
    if (v > LOG2_W'(LOG2_MAX)) r = LOG2_W'(LOG2_MAX);
    return r;
  endfunction

  // tree level of a heap-ordered node: floor(log2(n+1))
  function automatic logic [LVL_W-1:0] node_level(input logic [NODE_W-1:0] n);
    logic [NODE_W:0]  m;
    logic [LVL_W-1:0] lv;
    m  = {1'b0, n} + (NODE_W+1)'(1);
    lv = '0;
    for (int b = 0; b <= NODE_W; b++) begin
      if (m[b]) lv = LVL_W'(b);
    end
    return lv;
  endfunction

  function automatic occ_t occ_merge(input occ_t l, input occ_t r);
    occ_t o;
    if (l == OCC_FREE && r == OCC_FREE) o = OCC_FREE;
    else if (l == OCC_FULL && r == OCC_FULL) o = OCC_FULL;
    else o = OCC_PART;
    return o;
  endfunction

endpackage
`default_nettype wire

[sv/bba_if.sv]
// Interfaces: request and result channels of the buddy block allocator.
`default_nettype none
interface bba_in_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, op, size, address, input ready);
  modport sink   (input valid, op, size, address, output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   block_address;
  logic [LVL_W-1:0]    block_level;
  logic [SIZE_W-1:0]   free_bytes;
  logic [SIZE_W-1:0]   used_bytes;

  modport source (output valid, status, block_address, block_level, free_bytes, used_bytes,
                  input ready);
  modport sink   (input valid, status, block_address, block_level, free_bytes, used_bytes,
                  output ready);
endinterface
`default_nettype wire

[sv/bba_ctrl.sv]
// Controller: sequencer for search, free lookup and tree sweep of the allocator.
`default_nettype none
module bba_ctrl import bba_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire bba_stat_t stat,
  output bba_cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_SRCH_RD  = 8'b0000_0100,
    S_SRCH_CHK = 8'b0000_1000,
    S_FLOOK    = 8'b0001_0000,
    S_SWP_RD   = 8'b0010_0000,
    S_SWP_WR   = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] idx_r, idx_nxt;
  status_t           code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    code_nxt  = code_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.status = code_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.lvl_latch = 1'b1;
        idx_nxt       = '0;
        if (stat.op == OP_ALLOC) begin
          if (stat.too_big) begin
            code_nxt  = ST_NOSPACE;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end else begin
          if (!stat.in_range) begin
            code_nxt  = ST_NOTALLOC;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_FLOOK;
          end
        end
      end
      S_SRCH_RD: begin
        cmd.rd_search = 1'b1;
        state_nxt     = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (stat.occ_free) begin
          cmd.take_alloc = 1'b1;
          idx_nxt        = NODE_W'(NODE_COUNT - 1);
          state_nxt      = S_SWP_RD;
        end else if (idx_r == NODE_W'((1 << stat.lvl) - 1)) begin
          code_nxt  = ST_NOSPACE;
          state_nxt = S_RESULT;
        end else begin
          idx_nxt   = idx_r + NODE_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_FLOOK: begin
        if (stat.flook_hit) begin
          cmd.take_free = 1'b1;
          idx_nxt       = NODE_W'(NODE_COUNT - 1);
          state_nxt     = S_SWP_RD;
        end else if (idx_r == NODE_W'(DEEPEST_LEVEL)) begin
          code_nxt  = ST_NOTALLOC;
          state_nxt = S_RESULT;
        end else begin
          idx_nxt = idx_r + NODE_W'(1);
        end
      end
      S_SWP_RD: begin
        state_nxt = S_SWP_WR;
      end
      S_SWP_WR: begin
        cmd.wr_node = 1'b1;
        if (idx_r == '0) begin
          code_nxt  = ST_OK;
          state_nxt = S_RESULT;
        end else begin
          idx_nxt   = idx_r - NODE_W'(1);
          state_nxt = S_SWP_RD;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/bba_dp.sv]
// Datapath: tree state memory, allocation marks, byte counters and result register.
`default_nettype none
module bba_dp import bba_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bba_cmd_t              cmd,
  output bba_stat_t                  stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_op,
  input  wire logic [SIZE_W-1:0]     in_size,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [ADDR_W-1:0]          out_block_address,
  output logic [LVL_W-1:0]           out_block_level,
  output logic [SIZE_W-1:0]          out_free_bytes,
  output logic [SIZE_W-1:0]          out_used_bytes
);

  logic [ADDR_W-1:0]     base_r;
  logic [LOG2_W-1:0]     log2_r;
  op_t                   op_r;
  logic [SIZE_W-1:0]     size_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [ADDR_W-1:0]     off_r;
  logic [LVL_W-1:0]      lvl_r;
  logic [NODE_W-1:0]     tgt_r;
  logic [ADDR_W-1:0]     blk_addr_r;
  occ_t                  occ_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] occ_vld_r;
  logic [NODE_COUNT-1:0] alloc_r;
  occ_t                  rd_a_r, rd_b_r;
  logic [SIZE_W-1:0]     free_cnt_r, used_cnt_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [LVL_W-1:0]      out_level_r;

  logic [LOG2_W-1:0]     eff;
  logic [ADDR_W-1:0]     total;
  logic [LVL_W-1:0]      lvl_calc;
  logic [NODE_W-1:0]     srch_node;
  logic [NODE_W:0]       cl_w, cr_w;
  logic [NODE_W-1:0]     rd_a_addr, rd_b_addr;
  logic [LVL_W-1:0]      fl_d;
  logic [LOG2_W-1:0]     fl_sh;
  logic [ADDR_W-1:0]     fl_mask;
  logic [NODE_W-1:0]     fl_node;
  logic                  fl_hit;
  logic [LVL_W-1:0]      n_lvl;
  logic [NODE_W:0]       n_p1, t_p1;
  logic                  in_sub, is_anc;
  occ_t                  wr_val;
  logic [LOG2_W-1:0]     blk_sh;
  logic [SIZE_W-1:0]     bs;
  logic                  res_ok;
  logic [SIZE_W-1:0]     free_nxt, used_nxt;

  assign eff   = eff_log2(log2_r);
  assign total = ADDR_W'(1) << eff;

  always_comb begin
    lvl_calc = '0;
    for (int k = 1; k <= DEEPEST_LEVEL; k++) begin
      if ((total >> k) >= ADDR_W'(size_r)) lvl_calc = LVL_W'(k);
    end
  end

  // read addresses: search node, or the two children of the swept node
  assign srch_node = NODE_W'((1 << lvl_r) - 1) + cmd.idx;
  assign cl_w      = {cmd.idx, 1'b1};
  assign cr_w      = cl_w + (NODE_W+1)'(1);

  always_comb begin
    rd_a_addr = (cl_w < (NODE_W+1)'(NODE_COUNT)) ? cl_w[NODE_W-1:0] : '0;
    rd_b_addr = (cr_w < (NODE_W+1)'(NODE_COUNT)) ? cr_w[NODE_W-1:0] : '0;
    if (cmd.rd_search) rd_a_addr = srch_node;
  end

  // free lookup at level fl_d
  assign fl_d    = LVL_W'(cmd.idx);
  assign fl_sh   = eff - LOG2_W'(fl_d);
  assign fl_mask = (ADDR_W'(1) << fl_sh) - ADDR_W'(1);
  assign fl_node = NODE_W'((1 << fl_d) - 1) + NODE_W'(off_r >> fl_sh);
  assign fl_hit  = ((off_r & fl_mask) == '0) && alloc_r[fl_node];

  // sweep: subtree membership and ancestry of the swept node
  assign n_lvl = node_level(cmd.idx);
  assign n_p1  = {1'b0, cmd.idx} + (NODE_W+1)'(1);
  assign t_p1  = {1'b0, tgt_r} + (NODE_W+1)'(1);
  assign in_sub = (n_lvl >= lvl_r) && ((n_p1 >> (n_lvl - lvl_r)) == t_p1);
  assign is_anc = (n_lvl < lvl_r) && ((t_p1 >> (lvl_r - n_lvl)) == n_p1);

  always_comb begin
    if (in_sub) wr_val = (op_r == OP_ALLOC) ? OCC_FULL : OCC_FREE;
    else wr_val = occ_merge(rd_a_r, rd_b_r);
  end

  // counters
  assign blk_sh = eff - LOG2_W'(lvl_r);
  assign bs     = SIZE_W'(1) << blk_sh;
  assign res_ok = (cmd.status == ST_OK);

  always_comb begin
    free_nxt = free_cnt_r;
    used_nxt = used_cnt_r;
    if (res_ok) begin
      if (op_r == OP_ALLOC) begin
        free_nxt = (free_cnt_r >= bs) ? free_cnt_r - bs : '0;
        used_nxt = used_cnt_r + bs;
      end else begin
        free_nxt = free_cnt_r + bs;
        used_nxt = (used_cnt_r >= bs) ? used_cnt_r - bs : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      log2_r      <= LOG2_W'(LOG2_RESET);
      free_cnt_r  <= SIZE_W'(1) << eff_log2(LOG2_W'(LOG2_RESET));
      used_cnt_r  <= '0;
      alloc_r     <= '0;
      occ_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BASE_ADDRESS: begin
            base_r <= cfg_data[ADDR_W-1:0];
          end
          CFG_LOG2_TOTAL_SIZE: begin
            log2_r     <= cfg_data[LOG2_W-1:0];
            free_cnt_r <= SIZE_W'(1) << eff_log2(cfg_data[LOG2_W-1:0]);
            used_cnt_r <= '0;
            alloc_r    <= '0;
            occ_vld_r  <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.take_alloc) alloc_r[srch_node] <= 1'b1;
      if (cmd.take_free) alloc_r[fl_node] <= 1'b0;
      if (cmd.wr_node && (in_sub || is_anc)) occ_vld_r[cmd.idx] <= 1'b1;
      if (cmd.result) begin
        free_cnt_r  <= free_nxt;
        used_cnt_r  <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // occupancy memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.wr_node && (in_sub || is_anc)) occ_mem[cmd.idx] <= wr_val;
    rd_a_r <= occ_vld_r[rd_a_addr] ? occ_mem[rd_a_addr] : OCC_FREE;
    rd_b_r <= occ_vld_r[rd_b_addr] ? occ_mem[rd_b_addr] : OCC_FREE;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      size_r <= in_size;
      addr_r <= in_address;
      off_r  <= in_address - base_r;
    end
    if (cmd.lvl_latch) lvl_r <= lvl_calc;
    if (cmd.take_alloc) begin
      tgt_r      <= srch_node;
      blk_addr_r <= base_r + (ADDR_W'(cmd.idx) << (eff - LOG2_W'(lvl_r)));
    end
    if (cmd.take_free) begin
      tgt_r      <= fl_node;
      lvl_r      <= fl_d;
      blk_addr_r <= addr_r;
    end
    if (cmd.result) begin
      out_status_r <= cmd.status;
      out_addr_r   <= res_ok ? blk_addr_r : '0;
      out_level_r  <= res_ok ? lvl_r : '0;
    end
  end

  always_comb begin
    stat           = '0;
    stat.op        = op_r;
    stat.too_big   = size_r > free_cnt_r;
    stat.in_range  = off_r < total;
    stat.occ_free  = (rd_a_r == OCC_FREE);
    stat.flook_hit = fl_hit;
    stat.lvl       = lvl_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_level   = out_level_r;
  assign out_free_bytes    = free_cnt_r;
  assign out_used_bytes    = used_cnt_r;

endmodule
`default_nettype wire

[sv/buddy_block_allocator.sv]
// Top level: buddy block allocator, controller plus datapath; one word at a time.
// An accepted word is checked first; a size or range failure goes straight to the result.
// Otherwise an allocate probes the nodes of its level one by one and a free looks for a
// mark from the root level down; a hit adds a sweep over all 31 nodes, last back to root.
// A new word is taken only once the last result is registered; the sweep sets the pace.
// Synchronous active-low reset: tree all free, no marks, 2^20 free bytes, base address zero.
`default_nettype none
module buddy_block_allocator import bba_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bba_in_if.sink                     in_req,
  bba_out_if.source                  out_rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  bba_cmd_t  cmd;
  bba_stat_t stat;
  logic      in_ready;

  assign in_req.ready = in_ready;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_req.op),
    .in_size           (in_req.size),
    .in_address        (in_req.address),
    .out_ready         (out_rsp.ready),
    .out_valid         (out_rsp.valid),
    .out_status        (out_rsp.status),
    .out_block_address (out_rsp.block_address),
    .out_block_level   (out_rsp.block_level),
    .out_free_bytes    (out_rsp.free_bytes),
    .out_used_bytes    (out_rsp.used_bytes)
  );

endmodule
`default_nettype wire

[sv/bba_checker.sv]
// Checker: port-level assertions for the buddy block allocator, with its bind.
`default_nettype none
module bba_sva_checker import bba_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [ADDR_W-1:0]   out_block_address,
  input wire logic [LVL_W-1:0]    out_block_level
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // one word in flight: no new word straight after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken twice in a row");

  // a result never rises straight after acceptance: the check state comes first
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared too early");

  // failures carry no block
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_block_address == '0 && out_block_level == '0))
    else $error("failed result carries a block");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
                                   && $stable(out_block_address)))
    else $error("stalled result changed");

endmodule

bind buddy_block_allocator bba_sva_checker u_bba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_block_address (out_rsp.block_address),
  .out_block_level   (out_rsp.block_level)
);
`default_nettype wire

[tb/bba_checker.sv]
// Checker: watches the request, result and register ports, predicts each result word and compares.
module bba_checker import bba_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bba_in_if                          in_ch,
  bba_out_if                         out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t            status;
    logic [ADDR_W-1:0]  addr;
    logic [LVL_W-1:0]   lvl;
    logic [SIZE_W-1:0]  free_b;
    logic [SIZE_W-1:0]  used_b;
  } tree_reply_t;

  occ_t              tree_occ [NODE_COUNT];
  bit                live_mark [NODE_COUNT];
  logic [SIZE_W-1:0] bytes_free;
  logic [SIZE_W-1:0] bytes_used;
  logic [ADDR_W-1:0] region_base;
  logic [LOG2_W-1:0] region_log2;
  tree_reply_t       replies_due [$];
  int                mismatches = 0;

  function automatic int unsigned region_span();
    int unsigned v;
    v = region_log2;
    if (v < LOG2_MIN) v = LOG2_MIN;
    if (v > LOG2_MAX) v = LOG2_MAX;
    return v;
  endfunction

  function automatic void clear_tree();
    foreach (tree_occ[n]) begin
      tree_occ[n]  = OCC_FREE;
      live_mark[n] = 1'b0;
    end
    bytes_free = SIZE_W'(64'd1 << region_span());
    bytes_used = '0;
  endfunction

  function automatic void paint_subtree(int unsigned n, int unsigned d, occ_t v);
    int unsigned first;
    for (int unsigned k = d; k <= DEEPEST_LEVEL; k++) begin
      first = ((n + 1) << (k - d)) - 1;
      for (int unsigned j = 0; j < (1 << (k - d)); j++) tree_occ[first + j] = v;
    end
  endfunction

  function automatic void settle_parents(int unsigned n);
    int unsigned p;
    while (n > 0) begin
      p = (n - 1) / 2;
      if (tree_occ[2*p+1] == OCC_FREE && tree_occ[2*p+2] == OCC_FREE) tree_occ[p] = OCC_FREE;
      else if (tree_occ[2*p+1] == OCC_FULL && tree_occ[2*p+2] == OCC_FULL) tree_occ[p] = OCC_FULL;
      else tree_occ[p] = OCC_PART;
      n = p;
    end
  endfunction

  function automatic tree_reply_t serve_request(op_t op, logic [SIZE_W-1:0] size,
                                                logic [ADDR_W-1:0] address);
    tree_reply_t       r;
    int unsigned       lg, lvl, n;
    longint unsigned   whole, bs, off;
    bit                hit;
    lg       = region_span();
    whole    = 64'd1 << lg;
    r.status = ST_OK;
    r.addr   = '0;
    r.lvl    = '0;
    hit      = 1'b0;
    if (op == OP_ALLOC) begin
      if (size > bytes_free) begin
        r.status = ST_NOSPACE;
      end else begin
        lvl = 0;
        bs  = whole;
        while (lvl < DEEPEST_LEVEL && (bs >> 1) >= size) begin
          bs >>= 1;
          lvl++;
        end
        for (int unsigned i = 0; i < (1 << lvl) && !hit; i++) begin
          n = (1 << lvl) - 1 + i;
          if (tree_occ[n] == OCC_FREE) begin
            hit          = 1'b1;
            live_mark[n] = 1'b1;
            paint_subtree(n, lvl, OCC_FULL);
            settle_parents(n);
            r.addr     = ADDR_W'(64'(region_base) + 64'(i) * bs);
            r.lvl      = LVL_W'(lvl);
            bytes_free = (bytes_free >= bs) ? bytes_free - SIZE_W'(bs) : '0;
            bytes_used = SIZE_W'(bytes_used + bs);
          end
        end
        if (!hit) r.status = ST_NOSPACE;
      end
    end else begin
      off = 64'(ADDR_W'(address - region_base));
      if (off < whole) begin
        for (int unsigned d = 0; d <= DEEPEST_LEVEL && !hit; d++) begin
          bs = 64'd1 << (lg - d);
          if ((off & (bs - 1)) == 0) begin
            n = (1 << d) - 1 + int'(off >> (lg - d));
            if (live_mark[n]) begin
              hit          = 1'b1;
              live_mark[n] = 1'b0;
              paint_subtree(n, d, OCC_FREE);
              settle_parents(n);
              r.addr     = address;
              r.lvl      = LVL_W'(d);
              bytes_free = SIZE_W'(bytes_free + bs);
              bytes_used = (bytes_used >= bs) ? bytes_used - SIZE_W'(bs) : '0;
            end
          end
        end
      end
      if (!hit) r.status = ST_NOTALLOC;
    end
    r.free_b = bytes_free;
    r.used_b = bytes_used;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    tree_reply_t want;
    if (!rst_n) begin
      region_base = '0;
      region_log2 = LOG2_W'(LOG2_RESET);
      clear_tree();
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx_t'(cfg_index) == CFG_BASE_ADDRESS) begin
          region_base = cfg_data;
        end else begin
          region_log2 = cfg_data[LOG2_W-1:0];
          clear_tree();
        end
      end
      if (in_ch.valid && in_ch.ready)
        replies_due.push_back(serve_request(op_t'(in_ch.op), in_ch.size, in_ch.address));
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          $error("result word with nothing outstanding");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("block_address", want.addr, out_ch.block_address);
          check_field("block_level", want.lvl, out_ch.block_level);
          check_field("free_bytes", want.free_b, out_ch.free_bytes);
          check_field("used_bytes", want.used_b, out_ch.used_bytes);
        end
      end
    end
    pending    <= replies_due.size();
    fail_count <= mismatches;
  end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, request stimulus, result back-pressure, region set-up and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int                CYCLE_LIMIT  = 400_000;
  localparam int                PHASE_WORDS  = 80;
  localparam int                DRAIN_CYCLES = 120;
  localparam logic [ADDR_W-1:0] WRAP_BASE    = 48'hFFFF_FFFF_FFF8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  buddy_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_rsp   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bba_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL buddy_block_allocator");
      $finish;
    end
  end

  // result back-pressure in four modes, redrawn at random by a free-running tick counter
  int unsigned rx_tick = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 128 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 9) < 7);
      2:       out_ch.ready <= (rx_tick % 5 != 0);
      default: out_ch.ready <= rx_tick[4];
    endcase
  end

  // addresses of blocks handed out, so that a share of the frees names a live block
  op_t               ops_in_flight [$];
  logic [ADDR_W-1:0] live_blocks [$];
  always @(posedge clk) begin
    op_t done_op;
    if (in_ch.valid && in_ch.ready) ops_in_flight.push_back(op_t'(in_ch.op));
    if (out_ch.valid && out_ch.ready && ops_in_flight.size() != 0) begin
      done_op = ops_in_flight.pop_front();
      if (done_op == OP_ALLOC && status_t'(out_ch.status) == ST_OK)
        live_blocks.push_back(out_ch.block_address);
    end
  end

  logic [ADDR_W-1:0] region_base = '0;
  int unsigned       region_span = LOG2_RESET;

  task automatic send_word(op_t op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] address);
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.size    <= size;
    in_ch.address <= address;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_region(bit set_base, logic [ADDR_W-1:0] base,
                                bit set_size, logic [LOG2_W-1:0] log2v);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if (set_base) begin
      cfg_we      <= 1'b1;
      cfg_index   <= CFG_BASE_ADDRESS;
      cfg_data    <= base;
      region_base  = base;
      @(posedge clk);
    end
    if (set_size) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_LOG2_TOTAL_SIZE;
      cfg_data  <= {junk[CFG_DATA_W-LOG2_W-1:0], log2v};
      region_span = (log2v < LOG2_MIN) ? LOG2_MIN : (log2v > LOG2_MAX) ? LOG2_MAX : log2v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    live_blocks.delete();
  endtask

  task automatic send_random();
    int unsigned     pick, d, k;
    longint unsigned bs, r64;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(0, 99);
    r64  = {$urandom, $urandom};
    if (pick < 45) begin
      d  = $urandom_range(0, 9);
      d  = (d < 1) ? 0 : (d < 2) ? 1 : (d < 4) ? 2 : (d < 7) ? 3 : 4;
      bs = 64'd1 << (region_span - d);
      if (d == DEEPEST_LEVEL) send_word(OP_ALLOC, SIZE_W'(r64 % (bs + 1)), ADDR_W'(r64));
      else send_word(OP_ALLOC, SIZE_W'(bs / 2 + 1 + r64 % (bs / 2)), ADDR_W'(r64));
    end else if (pick < 80) begin
      if (live_blocks.size() != 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
      end else begin
        d = $urandom_range(0, DEEPEST_LEVEL);
        a = ADDR_W'(64'(region_base) +
                    (64'($urandom_range(0, (1 << d) - 1)) << (region_span - d)));
      end
      send_word(OP_FREE, SIZE_W'(r64), a);
    end else if (pick < 90) begin
      send_word(OP_ALLOC, SIZE_W'(r64 >> $urandom_range(0, 63)), ADDR_W'(r64));
    end else begin
      send_word(OP_FREE, SIZE_W'(r64), ADDR_W'(r64));
    end
  endtask

  initial begin
    int unsigned left, burst, gap;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_ALLOC;
    in_ch.size    = '0;
    in_ch.address = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_BASE_ADDRESS;
    cfg_data      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // region after reset: base 0, 1 MiB
    send_word(OP_ALLOC, 41'd0, 48'd0);
    send_word(OP_ALLOC, 41'd65536, 48'd0);
    send_word(OP_ALLOC, 41'd65537, 48'd0);
    send_word(OP_ALLOC, {SIZE_W{1'b1}}, {ADDR_W{1'b1}});
    send_word(OP_ALLOC, 41'd1048576, 48'd0);
    send_word(OP_FREE, 41'd0, 48'd0);
    send_word(OP_FREE, 41'd0, 48'd0);
    send_word(OP_FREE, 41'd0, 48'd1048576);
    send_word(OP_FREE, 41'd0, {ADDR_W{1'b1}});
    send_word(OP_FREE, 41'd0, 48'd65537);
    send_word(OP_FREE, 41'd0, 48'd131072);
    send_word(OP_FREE, 41'd0, 48'd65536);
    send_word(OP_ALLOC, 41'd1048576, 48'd0);
    send_word(OP_FREE, 41'd0, 48'd0);
    in_ch.valid <= 1'b0;

    // smallest region just below the top of the address space, so addresses wrap
    wait_drained();
    program_region(1'b1, WRAP_BASE, 1'b1, 6'd0);
    send_word(OP_ALLOC, 41'd1, 48'd0);
    send_word(OP_ALLOC, 41'd8, 48'd0);
    send_word(OP_ALLOC, 41'd4, 48'd0);
    send_word(OP_ALLOC, 41'd2, 48'd0);
    send_word(OP_ALLOC, 41'd1, 48'd0);
    send_word(OP_FREE, 41'd0, WRAP_BASE + 48'd1);
    send_word(OP_FREE, 41'd0, WRAP_BASE + 48'd4);
    // enough bytes free, but fragmented: no free node at that level
    send_word(OP_ALLOC, 41'd5, 48'd0);
    send_word(OP_FREE, 41'd0, 48'd0);
    in_ch.valid <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0:       program_region(1'b1, ADDR_W'({$urandom, $urandom}), 1'b1, 6'd63);
        1:       program_region(1'b1, '0, 1'b1, LOG2_W'($urandom_range(LOG2_MIN, LOG2_MAX)));
        2:       program_region(1'b1, {ADDR_W{1'b1}}, 1'b1, 6'd40);
        3:       program_region(1'b1, ADDR_W'({$urandom, $urandom}), 1'b0, '0);
        default: program_region(1'b1, ADDR_W'({$urandom, $urandom}), 1'b1,
                                LOG2_W'($urandom_range(0, 63)));
      endcase
      left = PHASE_WORDS;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && left > 0; b++) begin
          send_random();
          left--;
        end
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_ch.valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS buddy_block_allocator");
    end else begin
      $display("FAIL buddy_block_allocator");
    end
    $finish;
  end

endmodule

[buddy_block_allocator.f]
sv/bba_pkg.sv
sv/bba_if.sv
sv/bba_ctrl.sv
sv/bba_dp.sv
sv/buddy_block_allocator.sv
sv/bba_checker.sv
tb/bba_checker.sv
tb/testbench.sv
